FILE: rtl/fair_share_cap_allocator_core_defines.svh
// Assertion macros used by the allocator core.
`ifndef FAIR_SHARE_CAP_ALLOCATOR_CORE_DEFINES_SVH
`define FAIR_SHARE_CAP_ALLOCATOR_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define FSCA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fsca check failed");

// Check that cons holds in the cycle after ante.
`define FSCA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fsca check failed");

`endif

FILE: rtl/fsca_pkg.sv
`default_nettype none
package fsca_pkg;
    localparam int HEAP_DEPTH  = 1024;
    localparam int AMOUNT_BITS = 20;
    localparam int COUNT_BITS  = $clog2(HEAP_DEPTH + 1);
    localparam int BUDGET_BITS = 32;
    localparam int QSTEP_BITS  = $clog2(BUDGET_BITS);

    typedef logic [AMOUNT_BITS-1:0] amount_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [BUDGET_BITS-1:0] budget_t;

    typedef struct packed {
        logic    insert;
        logic    pop;
        amount_t amount;
    } cell_ctrl_t;
endpackage
`default_nettype wire

FILE: rtl/fsca_cell.sv
`default_nettype none
module fsca_cell (
    input  wire                  aclk,
    input  fsca_pkg::cell_ctrl_t ctrl,
    input  wire                  occupied,
    input  fsca_pkg::amount_t    left_val,
    input  wire                  left_gt,
    input  fsca_pkg::amount_t    right_val,
    output fsca_pkg::amount_t    val,
    output logic                 gt
);
    import fsca_pkg::*;

    amount_t val_reg;
    amount_t val_next;

    assign val = val_reg;
    assign gt  = occupied && (val_reg > ctrl.amount);

    always_comb begin
        val_next = val_reg;
        if (ctrl.insert) begin
            if (left_gt) begin
                val_next = left_val;
            end else if (gt || !occupied) begin
                val_next = ctrl.amount;
            end
        end else if (ctrl.pop) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end
endmodule
`default_nettype wire

FILE: rtl/fsca_div.sv
`default_nettype none
module fsca_div (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                start,
    input  fsca_pkg::budget_t  dividend,
    input  fsca_pkg::count_t   divisor,
    output logic               done,
    output fsca_pkg::amount_t  quotient
);
    import fsca_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [QSTEP_BITS-1:0] step_reg, step_next;
    count_t                rem_reg, rem_next;
    budget_t               quo_reg, quo_next;
    count_t                div_reg, div_next;
    logic [COUNT_BITS:0]   trial;

    assign done     = done_reg;
    assign quotient = quo_reg[AMOUNT_BITS-1:0];
    assign trial    = {rem_reg, quo_reg[BUDGET_BITS-1]} - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial[COUNT_BITS]) begin
                rem_next = {rem_reg[COUNT_BITS-2:0], quo_reg[BUDGET_BITS-1]};
                quo_next = {quo_reg[BUDGET_BITS-2:0], 1'b0};
            end else begin
                rem_next = trial[COUNT_BITS-1:0];
                quo_next = {quo_reg[BUDGET_BITS-2:0], 1'b1};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == QSTEP_BITS'(BUDGET_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
    end
endmodule
`default_nettype wire

FILE: rtl/fair_share_cap_allocator_core.sv
// Channel   Ports                                       Direction
// request   s_valid s_ready s_request_amount s_last_request   in
// result    m_valid m_ready m_cap_value m_requests_dropped    out
// config    cfg_valid cfg_ready cfg_total_budget        in
//
// A request without the last mark goes into the sorted cell row at once, unless it is zero or the row is full.
// A last request starts a walk over the granted requests, smallest first from cell 0;
// the walk then stops, the divider runs when the fair share limits the cap, and the
// result is finished.
// Reset clears control state only; the cell row needs no clearing.
// A pending result that is not taken stalls only the finish of the next walk.
`default_nettype none
`include "fair_share_cap_allocator_core_defines.svh"
module fair_share_cap_allocator_core (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    input  fsca_pkg::amount_t         s_request_amount,
    input  wire                       s_last_request,
    output logic                      m_valid,
    input  wire                       m_ready,
    output fsca_pkg::amount_t         m_cap_value,
    output logic                      m_requests_dropped,
    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  fsca_pkg::budget_t         cfg_total_budget
);
    import fsca_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DIV, ST_FINISH} state_t;

    state_t     state_reg, state_next;
    count_t     count_reg, count_next;
    budget_t    budget_reg;
    budget_t    rem_reg, rem_next;
    amount_t    largest_reg, largest_next;
    amount_t    cap_reg, cap_next;
    logic       ovf_reg, ovf_next;
    logic       m_valid_reg, m_valid_next;
    amount_t    m_cap_reg, m_cap_next;
    logic       m_drop_reg, m_drop_next;
    logic       div_start;
    logic       div_done;
    amount_t    div_quo;
    cell_ctrl_t ctrl;
    amount_t    cell_val [HEAP_DEPTH];
    logic       cell_gt  [HEAP_DEPTH];
    amount_t    smallest;
    logic [AMOUNT_BITS+COUNT_BITS-1:0] prod;
    logic       s_fire;

    assign s_ready            = (state_reg == ST_IDLE);
    assign cfg_ready          = 1'b1;
    assign m_valid            = m_valid_reg;
    assign m_cap_value        = m_cap_reg;
    assign m_requests_dropped = m_drop_reg;
    assign s_fire             = s_valid && s_ready;
    assign smallest           = cell_val[0];
    assign prod               = smallest * count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg <= '0;
        end else if (cfg_valid) begin
            budget_reg <= cfg_total_budget;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        largest_next = largest_reg;
        cap_next     = cap_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_cap_next   = m_cap_reg;
        m_drop_next  = m_drop_reg;
        div_start    = 1'b0;
        ctrl.insert  = 1'b0;
        ctrl.pop     = 1'b0;
        ctrl.amount  = s_request_amount;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_request_amount != '0) begin
                        if (count_reg < COUNT_BITS'(HEAP_DEPTH)) begin
                            ctrl.insert = 1'b1;
                            count_next  = count_reg + 1'b1;
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_last_request) begin
                        rem_next     = budget_reg;
                        largest_next = '0;
                        state_next   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (count_reg == '0) begin
                    cap_next   = largest_reg;
                    state_next = ST_FINISH;
                end else if ({1'b0, prod} > rem_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    rem_next   = rem_reg - BUDGET_BITS'(smallest);
                    if (smallest > largest_reg) begin
                        largest_next = smallest;
                    end
                    ctrl.pop   = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    cap_next   = div_quo;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_cap_next   = cap_reg;
                    m_drop_next  = ovf_reg;
                    count_next   = '0;
                    largest_next = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            largest_reg <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            largest_reg <= largest_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        rem_reg   <= rem_next;
        cap_reg   <= cap_next;
        m_cap_reg <= m_cap_next;
        m_drop_reg <= m_drop_next;
    end

    fsca_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rem_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
        amount_t left_val;
        logic    left_gt;
        amount_t right_val;
        if (i == 0) begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_mid
            assign left_val = cell_val[i-1];
            assign left_gt  = cell_gt[i-1];
        end
        if (i == HEAP_DEPTH - 1) begin : g_last
            assign right_val = cell_val[i];
        end else begin : g_body
            assign right_val = cell_val[i+1];
        end
        fsca_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (COUNT_BITS'(i) < count_reg),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val       (cell_val[i]),
            .gt        (cell_gt[i])
        );
    end

    `FSCA_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= COUNT_BITS'(HEAP_DEPTH))
    `FSCA_ASSERT_SAME(a_pop_nonempty, ctrl.pop, count_reg != '0 && state_reg == ST_WALK)
    `FSCA_ASSERT_SAME(a_insert_room, ctrl.insert, count_reg < COUNT_BITS'(HEAP_DEPTH))
    `FSCA_ASSERT_SAME(a_div_done_state, div_done, state_reg == ST_DIV)
    `FSCA_ASSERT_NEXT(a_finish_emits, state_reg == ST_FINISH && (!m_valid_reg || m_ready),
                      m_valid_reg && state_reg == ST_IDLE)
endmodule
`default_nettype wire
